// ----- design/vlpg_pkg.sv -----
package vlpg_pkg;

    typedef logic signed [8:0] coord_t;
    typedef logic [8:0] delta_t;
    typedef logic signed [9:0] err_t;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] DAC_OFFSET_RESET = 8'd127;

    typedef struct packed {
        logic   is_line;
        logic   degenerate;
        logic   steep;
        logic   major_neg;
        logic   minor_neg;
        coord_t major_start;
        coord_t minor_start;
        coord_t major_end;
        delta_t delta_major;
        delta_t delta_minor;
    } op_t;

    typedef struct packed {
        logic [7:0] x_code;
        logic [7:0] y_code;
        logic       last;
    } res_t;

endpackage

// ----- design/vlpg_fifo.sv -----
module vlpg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/vlpg_front.sv -----
module vlpg_front
    import vlpg_pkg::*;
(
    input  logic   kind,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    output op_t    op
);

    logic signed [9:0] dx, dy, ndx, ndy;
    delta_t            adx, ady;
    logic              steep;
    coord_t            minor_end;

    always_comb
    begin
        dx  = 10'(x_end) - 10'(x_start);
        dy  = 10'(y_end) - 10'(y_start);
        ndx = -dx;
        ndy = -dy;
        adx = dx[9] ? ndx[8:0] : dx[8:0];
        ady = dy[9] ? ndy[8:0] : dy[8:0];
        steep = (ady > adx);

        op            = '0;
        op.is_line    = (kind == KIND_LINE);
        op.degenerate = (x_start == x_end) && (y_start == y_end);
        op.steep      = steep;
        if (steep)
        begin
            op.major_start = y_start;
            op.minor_start = x_start;
            op.major_end   = y_end;
            minor_end      = x_end;
            op.delta_major = ady;
            op.delta_minor = adx;
        end
        else
        begin
            op.major_start = x_start;
            op.minor_start = y_start;
            op.major_end   = x_end;
            minor_end      = y_end;
            op.delta_major = adx;
            op.delta_minor = ady;
        end
        op.major_neg = (op.major_start > op.major_end);
        op.minor_neg = (op.minor_start > minor_end);
    end

endmodule

// ----- design/vlpg_back.sv -----
module vlpg_back
    import vlpg_pkg::*;
#(
    parameter int DAC_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       op_valid,
    input  op_t        op,
    output logic       op_take,
    input  logic       res_full,
    output logic       res_push,
    output res_t       res
);

    localparam int SUM_W = (DAC_BITS + 2 > 11) ? DAC_BITS + 2 : 11;
    localparam logic signed [SUM_W-1:0] MAX_CODE = SUM_W'((1 << DAC_BITS) - 1);

    logic [7:0] dac_offset_reg;
    coord_t     beam_x_reg, beam_x_next;
    coord_t     beam_y_reg, beam_y_next;
    logic       active_reg, active_next;
    logic       start_pending_reg, start_pending_next;
    coord_t     major_pos_reg, major_pos_next;
    coord_t     minor_pos_reg, minor_pos_next;
    coord_t     major_end_reg, major_end_next;
    delta_t     delta_major_reg, delta_major_next;
    delta_t     delta_minor_reg, delta_minor_next;
    err_t       error_acc_reg, error_acc_next;
    logic [2:0] flags_reg, flags_next;

    coord_t            step_major, step_minor, emit_major, emit_minor, emit_x, emit_y;
    logic signed [10:0] err_sub, err_add;
    logic              emit_last;

    function automatic logic [7:0] to_code(coord_t c, logic [7:0] off);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(c) + SUM_W'($signed({1'b0, off}));
        if (s < 0)
        begin
            return 8'd0;
        end
        else if (s > MAX_CODE)
        begin
            return MAX_CODE[7:0];
        end
        return s[7:0];
    endfunction

    assign op_take = op_valid && !res_full;

    always_comb
    begin
        beam_x_next        = beam_x_reg;
        beam_y_next        = beam_y_reg;
        active_next        = active_reg;
        start_pending_next = start_pending_reg;
        major_pos_next     = major_pos_reg;
        minor_pos_next     = minor_pos_reg;
        major_end_next     = major_end_reg;
        delta_major_next   = delta_major_reg;
        delta_minor_next   = delta_minor_reg;
        error_acc_next     = error_acc_reg;
        flags_next         = flags_reg;
        res_push           = 1'b0;

        step_major = major_pos_reg + (flags_reg[1] ? 9'h1FF : 9'h001);
        step_minor = minor_pos_reg;
        err_sub    = 11'(error_acc_reg) - 11'($signed({2'b00, delta_minor_reg}));
        err_add    = err_sub;
        if (err_sub < 0)
        begin
            step_minor = minor_pos_reg + (flags_reg[0] ? 9'h1FF : 9'h001);
            err_add    = err_sub + 11'($signed({2'b00, delta_major_reg}));
        end

        if (start_pending_reg)
        begin
            emit_major = major_pos_reg;
            emit_minor = minor_pos_reg;
            emit_last  = 1'b0;
        end
        else
        begin
            emit_major = step_major;
            emit_minor = step_minor;
            emit_last  = (step_major == major_end_reg);
        end
        emit_x = flags_reg[2] ? emit_minor : emit_major;
        emit_y = flags_reg[2] ? emit_major : emit_minor;

        res.x_code = to_code(emit_x, dac_offset_reg);
        res.y_code = to_code(emit_y, dac_offset_reg);
        res.last   = emit_last;

        if (op_take)
        begin
            if (op.is_line)
            begin
                active_next        = 1'b0;
                start_pending_next = 1'b0;
                if (!op.degenerate)
                begin
                    major_pos_next   = op.major_start;
                    minor_pos_next   = op.minor_start;
                    major_end_next   = op.major_end;
                    delta_major_next = op.delta_major;
                    delta_minor_next = op.delta_minor;
                    error_acc_next   = err_t'(op.delta_major >> 1);
                    flags_next       = {op.steep, op.major_neg, op.minor_neg};
                    active_next      = 1'b1;
                    if (op.steep)
                    begin
                        start_pending_next = !((beam_x_reg == op.minor_start)
                                            && (beam_y_reg == op.major_start));
                    end
                    else
                    begin
                        start_pending_next = !((beam_x_reg == op.major_start)
                                            && (beam_y_reg == op.minor_start));
                    end
                end
            end
            else if (active_reg)
            begin
                res_push    = 1'b1;
                beam_x_next = emit_x;
                beam_y_next = emit_y;
                if (start_pending_reg)
                begin
                    start_pending_next = 1'b0;
                end
                else
                begin
                    major_pos_next = step_major;
                    minor_pos_next = step_minor;
                    error_acc_next = err_add[9:0];
                    if (emit_last)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_offset_reg    <= DAC_OFFSET_RESET;
            beam_x_reg        <= '0;
            beam_y_reg        <= '0;
            active_reg        <= 1'b0;
            start_pending_reg <= 1'b0;
            major_pos_reg     <= '0;
            minor_pos_reg     <= '0;
            major_end_reg     <= '0;
            delta_major_reg   <= '0;
            delta_minor_reg   <= '0;
            error_acc_reg     <= '0;
            flags_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dac_offset_reg <= cfg_wdata;
            end
            beam_x_reg        <= beam_x_next;
            beam_y_reg        <= beam_y_next;
            active_reg        <= active_next;
            start_pending_reg <= start_pending_next;
            major_pos_reg     <= major_pos_next;
            minor_pos_reg     <= minor_pos_next;
            major_end_reg     <= major_end_next;
            delta_major_reg   <= delta_major_next;
            delta_minor_reg   <= delta_minor_next;
            error_acc_reg     <= error_acc_next;
            flags_reg         <= flags_next;
        end
    end

endmodule

// ----- design/vector_line_point_generator_unit.sv -----
// Vector line point generator: walks Bresenham lines and produces X/Y DAC codes.
// Input channel (push/full): a request with kind 0 loads a line from
// x_start/y_start to x_end/y_end; a request with kind 1 is a tick that asks
// for the next point. Ticks while no line runs, and line requests, give no
// result. A line whose endpoints are equal cancels the running line.
// Result channel (empty/pop): x_code, y_code and last, oldest first.
// cfg_we/cfg_wdata write the DAC offset; write it only while the block is idle.
// One request is taken per cycle while full is low. A tick's point reaches the
// result side by way of both queues: the decoded request is first written into
// the request queue, and the walker, one Bresenham step per tick, then takes
// it, steps and writes the result queue. Both queues hold two entries, so when
// the receiver stalls the walker stops at a full result queue and full rises
// once the request queue fills as well; nothing is dropped.
// Reset empties both queues, stops any line, puts the beam at the origin and
// sets the DAC offset to 127.
module vector_line_point_generator_unit
    import vlpg_pkg::*;
#(
    parameter int DAC_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  coord_t     x_start,
    input  coord_t     y_start,
    input  coord_t     x_end,
    input  coord_t     y_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] x_code,
    output logic [7:0] y_code,
    output logic       last
);

    op_t  front_op, queued_op;
    logic op_empty, op_take;
    logic res_full, res_push;
    res_t res_in, res_out;

    vlpg_front u_front (
        .kind    (kind),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .op      (front_op)
    );

    vlpg_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (2)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_op),
        .full  (full),
        .pop   (op_take),
        .rdata (queued_op),
        .empty (op_empty)
    );

    vlpg_back #(
        .DAC_BITS (DAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op_valid  (!op_empty),
        .op        (queued_op),
        .op_take   (op_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    vlpg_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign x_code = res_out.x_code;
    assign y_code = res_out.y_code;
    assign last   = res_out.last;

endmodule
